// ===== hw/rtl/vkf_pkg.sv =====
// Shared constants, types and escape-sequence tables for the VT100 key byte FIFO.
`default_nettype none
package vkf_pkg;

    localparam int RING_DEPTH = 512;
    localparam int MAX_READ   = 64;

    localparam int PTR_W   = $clog2(RING_DEPTH);
    localparam int CNT_W   = $clog2(RING_DEPTH + 1);
    localparam int BYTE_W  = 8;
    localparam int CLASS_W = 4;
    localparam int LIMIT_W = 7;
    localparam int FILL_W  = 10;
    localparam int IDX_W   = 2;
    localparam int LEN_W   = 3;

    // Key classes
    localparam logic [CLASS_W-1:0] KEY_OTHER     = 4'd0;
    localparam logic [CLASS_W-1:0] KEY_UP        = 4'd1;
    localparam logic [CLASS_W-1:0] KEY_DOWN      = 4'd2;
    localparam logic [CLASS_W-1:0] KEY_RIGHT     = 4'd3;
    localparam logic [CLASS_W-1:0] KEY_LEFT      = 4'd4;
    localparam logic [CLASS_W-1:0] KEY_BOL       = 4'd5;
    localparam logic [CLASS_W-1:0] KEY_END       = 4'd6;
    localparam logic [CLASS_W-1:0] KEY_INS       = 4'd7;
    localparam logic [CLASS_W-1:0] KEY_DEL       = 4'd8;
    localparam logic [CLASS_W-1:0] KEY_PGUP      = 4'd9;
    localparam logic [CLASS_W-1:0] KEY_PGDN      = 4'd10;
    localparam logic [CLASS_W-1:0] KEY_RET       = 4'd11;
    localparam logic [CLASS_W-1:0] KEY_BKSP      = 4'd12;

    // Request kinds
    localparam logic ACT_KEY  = 1'b0;
    localparam logic ACT_READ = 1'b1;

    // Character codes
    localparam logic [BYTE_W-1:0] CH_NUL = 8'h00;
    localparam logic [BYTE_W-1:0] CH_BS  = 8'h08;
    localparam logic [BYTE_W-1:0] CH_LF  = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_ESC = 8'h1B;
    localparam logic [BYTE_W-1:0] CH_LBR = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_TIL = 8'h7E;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PUSH,
        ST_READ_ADDR,
        ST_READ_DATA
    } vkf_state_t;

    function automatic logic is_seq_class(input logic [CLASS_W-1:0] cls);
        return (cls >= KEY_UP) && (cls <= KEY_PGDN);
    endfunction

    function automatic logic [LEN_W-1:0] seq_len(input logic [CLASS_W-1:0] cls);
        return (cls >= KEY_INS) ? 3'd4 : 3'd3;
    endfunction

    // Third byte of the sequence: final letter or the digit before the tilde
    function automatic logic [BYTE_W-1:0] seq_key_char(input logic [CLASS_W-1:0] cls);
        logic [BYTE_W-1:0] c;
        c = 8'h41;
        unique case (cls)
            KEY_UP:    c = 8'h41;
            KEY_DOWN:  c = 8'h42;
            KEY_RIGHT: c = 8'h43;
            KEY_LEFT:  c = 8'h44;
            KEY_BOL:   c = 8'h48;
            KEY_END:   c = 8'h46;
            KEY_INS:   c = 8'h32;
            KEY_DEL:   c = 8'h33;
            KEY_PGUP:  c = 8'h35;
            KEY_PGDN:  c = 8'h36;
            default:   c = 8'h41;
        endcase
        return c;
    endfunction

    function automatic logic [BYTE_W-1:0] seq_byte(input logic [CLASS_W-1:0] cls,
                                                    input logic [IDX_W-1:0]   idx);
        logic [BYTE_W-1:0] b;
        b = CH_ESC;
        unique case (idx)
            2'd0:    b = CH_ESC;
            2'd1:    b = CH_LBR;
            2'd2:    b = seq_key_char(cls);
            default: b = CH_TIL;
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/vkf_ring_ram.sv =====
// Simple dual-port byte ring memory with registered read.
`default_nettype none
module vkf_ring_ram #(
    parameter int DEPTH  = 512,
    parameter int WIDTH  = 8,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/key_event_to_vt100_byte_fifo_unit.sv =====
// Top level: key events to VT100 bytes in a ring, popped out by read requests.
// Key event: accepted, then its bytes (1, 3 or 4) are written one at a time
//   through the single write port of the ring memory.
// Read: each popped byte takes an address state, then a registered data state,
//   on the one read port; an empty or zero-limit read gives a single byteless beat.
// One item at a time; in_stall stays high until the item's last beat is registered.
// Reset clears pointers, fill count, state and the output valid; ring contents stay
//   undefined, as only written entries are ever read.
`default_nettype none
module key_event_to_vt100_byte_fifo_unit (
    input  wire logic       clk,
    input  wire logic       rst_n,
    // request channel
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic       action,
    input  wire logic       key_pressed,
    input  wire logic [3:0] key_class,
    input  wire logic [7:0] ascii_code,
    input  wire logic [6:0] read_limit,
    // result channel
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      out_byte,
    output logic            has_byte,
    output logic            last,
    output logic [9:0]      fill_level
);

    localparam int PTR_W  = vkf_pkg::PTR_W;
    localparam int CNT_W  = vkf_pkg::CNT_W;
    localparam int BYTE_W = vkf_pkg::BYTE_W;

    vkf_pkg::vkf_state_t state_reg, state_next;

    logic [PTR_W-1:0]            wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]            rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]            count_reg, count_next;

    // key event being pushed
    logic                        push_seq_reg, push_seq_next;
    logic [vkf_pkg::CLASS_W-1:0] push_cls_reg, push_cls_next;
    logic [BYTE_W-1:0]           push_code_reg, push_code_next;
    logic [vkf_pkg::IDX_W-1:0]   push_idx_reg, push_idx_next;
    logic [vkf_pkg::LEN_W-1:0]   push_len_reg, push_len_next;

    // bytes still allowed in the current read
    logic [vkf_pkg::LIMIT_W-1:0] rem_reg, rem_next;

    // output register
    logic                        out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]           out_byte_reg, out_byte_next;
    logic                        out_has_reg, out_has_next;
    logic                        out_last_reg, out_last_next;
    logic [vkf_pkg::FILL_W-1:0]  out_fill_reg, out_fill_next;

    // memory port signals
    logic                        ram_we;
    logic [BYTE_W-1:0]           ram_wdata;
    logic                        ram_re;
    logic [BYTE_W-1:0]           ram_rdata;

    logic                        in_take;
    logic                        out_free;
    logic                        out_load;
    logic [BYTE_W-1:0]           key_byte;
    logic [CNT_W-1:0]            count_dec;
    logic                        pop_done;

    assign in_stall = (state_reg != vkf_pkg::ST_IDLE);
    assign in_take  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign has_byte   = out_has_reg;
    assign last       = out_last_reg;
    assign fill_level = out_fill_reg;

    vkf_ring_ram #(
        .DEPTH (vkf_pkg::RING_DEPTH),
        .WIDTH (BYTE_W),
        .ADDR_W(PTR_W)
    ) u_ring (
        .clk  (clk),
        .we   (ram_we),
        .waddr(wr_ptr_reg),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(rd_ptr_reg),
        .rdata(ram_rdata)
    );

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(vkf_pkg::RING_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    // Map a plain press onto the single byte it pushes
    always_comb
    begin
        key_byte = ascii_code;
        if (ascii_code == vkf_pkg::CH_NUL)
        begin
            if (key_class == vkf_pkg::KEY_RET)
            begin
                key_byte = vkf_pkg::CH_LF;
            end
            else if (key_class == vkf_pkg::KEY_BKSP)
            begin
                key_byte = vkf_pkg::CH_BS;
            end
        end
    end

    assign count_dec = count_reg - CNT_W'(1);
    assign pop_done  = (rem_reg == vkf_pkg::LIMIT_W'(1)) ||
                       (ram_rdata == vkf_pkg::CH_LF) ||
                       (count_dec == '0);

    always_comb
    begin
        state_next     = state_reg;
        wr_ptr_next    = wr_ptr_reg;
        rd_ptr_next    = rd_ptr_reg;
        count_next     = count_reg;
        push_seq_next  = push_seq_reg;
        push_cls_next  = push_cls_reg;
        push_code_next = push_code_reg;
        push_idx_next  = push_idx_reg;
        push_len_next  = push_len_reg;
        rem_next       = rem_reg;
        out_load       = 1'b0;
        out_byte_next  = out_byte_reg;
        out_has_next   = out_has_reg;
        out_last_next  = out_last_reg;
        out_fill_next  = out_fill_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_wdata      = push_seq_reg ? vkf_pkg::seq_byte(push_cls_reg, push_idx_reg)
                                      : push_code_reg;

        unique case (state_reg)
            vkf_pkg::ST_IDLE:
            begin
                if (in_take)
                begin
                    if (action == vkf_pkg::ACT_READ)
                    begin
                        // saturate the limit
                        rem_next   = (read_limit > vkf_pkg::LIMIT_W'(vkf_pkg::MAX_READ))
                                     ? vkf_pkg::LIMIT_W'(vkf_pkg::MAX_READ) : read_limit;
                        state_next = vkf_pkg::ST_READ_ADDR;
                    end
                    else if (key_pressed)
                    begin
                        push_idx_next  = '0;
                        push_cls_next  = key_class;
                        push_code_next = key_byte;
                        if (vkf_pkg::is_seq_class(key_class))
                        begin
                            push_seq_next = 1'b1;
                            push_len_next = vkf_pkg::seq_len(key_class);
                            state_next    = vkf_pkg::ST_PUSH;
                        end
                        else
                        begin
                            push_seq_next = 1'b0;
                            push_len_next = vkf_pkg::LEN_W'(1);
                            // a zero code pushes nothing
                            if (key_byte != vkf_pkg::CH_NUL)
                            begin
                                state_next = vkf_pkg::ST_PUSH;
                            end
                        end
                    end
                end
            end

            vkf_pkg::ST_PUSH:
            begin
                // drop the byte when the ring is full
                if (count_reg < CNT_W'(vkf_pkg::RING_DEPTH))
                begin
                    ram_we      = 1'b1;
                    wr_ptr_next = ptr_inc(wr_ptr_reg);
                    count_next  = count_reg + CNT_W'(1);
                end
                push_idx_next = push_idx_reg + vkf_pkg::IDX_W'(1);
                if ({1'b0, push_idx_reg} == push_len_reg - vkf_pkg::LEN_W'(1))
                begin
                    state_next = vkf_pkg::ST_IDLE;
                end
            end

            vkf_pkg::ST_READ_ADDR:
            begin
                if ((count_reg == '0) || (rem_reg == '0))
                begin
                    // empty ring or zero limit: one beat without a byte
                    if (out_free)
                    begin
                        out_load      = 1'b1;
                        out_byte_next = vkf_pkg::CH_NUL;
                        out_has_next  = 1'b0;
                        out_last_next = 1'b1;
                        out_fill_next = vkf_pkg::FILL_W'(count_reg);
                        state_next    = vkf_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    ram_re     = 1'b1;
                    state_next = vkf_pkg::ST_READ_DATA;
                end
            end

            vkf_pkg::ST_READ_DATA:
            begin
                // hold the read data until the output register is free
                if (out_free)
                begin
                    out_load      = 1'b1;
                    out_byte_next = ram_rdata;
                    out_has_next  = 1'b1;
                    out_last_next = pop_done;
                    out_fill_next = vkf_pkg::FILL_W'(count_dec);
                    rd_ptr_next   = ptr_inc(rd_ptr_reg);
                    count_next    = count_dec;
                    rem_next      = rem_reg - vkf_pkg::LIMIT_W'(1);
                    state_next    = pop_done ? vkf_pkg::ST_IDLE : vkf_pkg::ST_READ_ADDR;
                end
            end

            default:
            begin
                state_next = vkf_pkg::ST_IDLE;
            end
        endcase

        out_valid_next = out_load || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= vkf_pkg::ST_IDLE;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        push_seq_reg  <= push_seq_next;
        push_cls_reg  <= push_cls_next;
        push_code_reg <= push_code_next;
        push_idx_reg  <= push_idx_next;
        push_len_reg  <= push_len_next;
        rem_reg       <= rem_next;
        out_byte_reg  <= out_byte_next;
        out_has_reg   <= out_has_next;
        out_last_reg  <= out_last_next;
        out_fill_reg  <= out_fill_next;
    end

    // The fill count never exceeds the ring depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(vkf_pkg::RING_DEPTH))
        else $error("fill count above ring depth");

    // A beat without a byte always closes its read
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_has_reg |-> out_last_reg)
        else $error("byteless beat not marked last");

    // Each popped byte takes exactly one off the fill count
    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == vkf_pkg::ST_READ_DATA) && out_free
        |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("pop did not decrement fill count");

    // A pop is only ever issued with bytes in the ring
    a_read_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |-> count_reg != '0)
        else $error("ring read issued while empty");

    // Writes never happen while a read is in progress
    a_no_write_in_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == vkf_pkg::ST_READ_ADDR || state_reg == vkf_pkg::ST_READ_DATA)
        |-> !ram_we)
        else $error("ring write during read");

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the VT100 key byte FIFO: a directed script, then random traffic.
module testbench;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 7;
    localparam int RANDOM_ITEMS  = 480;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 20;
    localparam int FLOOD_KEYS    = 200;

    // Key classes above backspace behave as plain keys
    localparam logic [vkf_pkg::CLASS_W-1:0] KEY_SPARE_LO = 4'd13;
    localparam logic [vkf_pkg::CLASS_W-1:0] KEY_SPARE_HI = 4'd15;

    // Plain character codes used by the script
    localparam logic [vkf_pkg::BYTE_W-1:0] CH_CR  = 8'h0D;
    localparam logic [vkf_pkg::BYTE_W-1:0] CH_A   = 8'h41;
    localparam logic [vkf_pkg::BYTE_W-1:0] CH_DEL = 8'h7F;
    localparam logic [vkf_pkg::BYTE_W-1:0] CH_TOP = 8'hFF;

    // One beat of the result channel
    typedef struct packed {
        logic [vkf_pkg::BYTE_W-1:0] data;
        logic                       has_data;
        logic                       closing;
        logic [vkf_pkg::FILL_W-1:0] fill;
    } read_beat_t;

    // One request, plus a typed-in beat where the answer is obvious
    typedef struct packed {
        logic                        act;
        logic                        pressed;
        logic [vkf_pkg::CLASS_W-1:0] cls;
        logic [vkf_pkg::BYTE_W-1:0]  code;
        logic [vkf_pkg::LIMIT_W-1:0] limit;
        logic                        typed;
        read_beat_t                  typed_beat;
    } key_request_t;

    localparam read_beat_t EMPTY_BEAT = '{vkf_pkg::CH_NUL, 1'b0, 1'b1, 10'd0};
    localparam read_beat_t NO_BEAT    = '0;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic               action;
    logic               key_pressed;
    logic [3:0]         key_class;
    logic [7:0]         ascii_code;
    logic [6:0]         read_limit;
    logic               out_valid;
    logic               out_stall;
    logic [7:0]         out_byte;
    logic               has_byte;
    logic               last;
    logic [9:0]         fill_level;

    // Our own copy of the ring, advanced at each accepted request
    logic [vkf_pkg::BYTE_W-1:0] ring_copy [vkf_pkg::RING_DEPTH];
    int                 ring_rd    = 0;
    int                 ring_wr    = 0;
    int                 ring_count = 0;

    read_beat_t         pending_beats [$];
    int                 mismatch_count = 0;
    int                 work_items     = 0;
    bit                 calm_sender    = 1'b0;
    bit                 hold_off_req   = 1'b0;

    // Directed script: reset state, limits, every key class and the odd corners
    key_request_t script [0:25] = '{
        // read straight after reset: ring empty
        '{vkf_pkg::ACT_READ, 1'b0, vkf_pkg::KEY_OTHER, vkf_pkg::CH_NUL, 7'd5,
          1'b1, EMPTY_BEAT},
        // zero limit on an empty ring, with noise on the key fields
        '{vkf_pkg::ACT_READ, 1'b1, vkf_pkg::KEY_BKSP, CH_TOP, 7'd0, 1'b1, EMPTY_BEAT},
        '{vkf_pkg::ACT_KEY, 1'b1, vkf_pkg::KEY_UP, vkf_pkg::CH_NUL, 7'd0, 1'b0, NO_BEAT},
        // zero limit pops nothing but reports the fill
        '{vkf_pkg::ACT_READ, 1'b0, vkf_pkg::KEY_OTHER, vkf_pkg::CH_NUL, 7'd0, 1'b1,
          '{vkf_pkg::CH_NUL, 1'b0, 1'b1, 10'd3}},
        // limit above the maximum saturates; ring empties after the arrow
        '{vkf_pkg::ACT_READ, 1'b0, vkf_pkg::KEY_OTHER, vkf_pkg::CH_NUL, 7'd127,
          1'b0, NO_BEAT},
        // release pushes nothing
        '{vkf_pkg::ACT_KEY, 1'b0, vkf_pkg::KEY_DEL, CH_TOP, 7'd127, 1'b0, NO_BEAT},
        // enter and backspace with no code
        '{vkf_pkg::ACT_KEY, 1'b1, vkf_pkg::KEY_RET, vkf_pkg::CH_NUL, 7'd0, 1'b0, NO_BEAT},
        '{vkf_pkg::ACT_KEY, 1'b1, vkf_pkg::KEY_BKSP, vkf_pkg::CH_NUL, 7'd0, 1'b0, NO_BEAT},
        // plain key with no code pushes nothing
        '{vkf_pkg::ACT_KEY, 1'b1, vkf_pkg::KEY_OTHER, vkf_pkg::CH_NUL, 7'd0,
          1'b0, NO_BEAT},
        '{vkf_pkg::ACT_KEY, 1'b1, vkf_pkg::KEY_OTHER, CH_TOP, 7'd0, 1'b0, NO_BEAT},
        // out-of-range classes behave as plain keys
        '{vkf_pkg::ACT_KEY, 1'b1, KEY_SPARE_LO, CH_A, 7'd0, 1'b0, NO_BEAT},
        '{vkf_pkg::ACT_KEY, 1'b1, KEY_SPARE_HI, vkf_pkg::CH_NUL, 7'd0, 1'b0, NO_BEAT},
        // enter and backspace keep a code they carry
        '{vkf_pkg::ACT_KEY, 1'b1, vkf_pkg::KEY_RET, CH_CR, 7'd0, 1'b0, NO_BEAT},
        '{vkf_pkg::ACT_KEY, 1'b1, vkf_pkg::KEY_BKSP, CH_DEL, 7'd0, 1'b0, NO_BEAT},
        // read stops after the newline, then on the limit
        '{vkf_pkg::ACT_READ, 1'b0, vkf_pkg::KEY_OTHER, vkf_pkg::CH_NUL, 7'd64,
          1'b0, NO_BEAT},
        '{vkf_pkg::ACT_READ, 1'b0, vkf_pkg::KEY_OTHER, vkf_pkg::CH_NUL, 7'd2,
          1'b0, NO_BEAT},
        // every remaining escape sequence
        '{vkf_pkg::ACT_KEY, 1'b1, vkf_pkg::KEY_DOWN, vkf_pkg::CH_NUL, 7'd0, 1'b0, NO_BEAT},
        '{vkf_pkg::ACT_KEY, 1'b1, vkf_pkg::KEY_RIGHT, CH_A, 7'd0, 1'b0, NO_BEAT},
        '{vkf_pkg::ACT_KEY, 1'b1, vkf_pkg::KEY_LEFT, vkf_pkg::CH_NUL, 7'd0, 1'b0, NO_BEAT},
        '{vkf_pkg::ACT_KEY, 1'b1, vkf_pkg::KEY_BOL, vkf_pkg::CH_NUL, 7'd0, 1'b0, NO_BEAT},
        '{vkf_pkg::ACT_KEY, 1'b1, vkf_pkg::KEY_END, vkf_pkg::CH_NUL, 7'd0, 1'b0, NO_BEAT},
        '{vkf_pkg::ACT_KEY, 1'b1, vkf_pkg::KEY_INS, vkf_pkg::CH_NUL, 7'd0, 1'b0, NO_BEAT},
        '{vkf_pkg::ACT_KEY, 1'b1, vkf_pkg::KEY_DEL, vkf_pkg::CH_NUL, 7'd0, 1'b0, NO_BEAT},
        '{vkf_pkg::ACT_KEY, 1'b1, vkf_pkg::KEY_PGUP, CH_TOP, 7'd0, 1'b0, NO_BEAT},
        '{vkf_pkg::ACT_KEY, 1'b1, vkf_pkg::KEY_PGDN, vkf_pkg::CH_NUL, 7'd0, 1'b0, NO_BEAT},
        // longest read: runs until the ring is empty
        '{vkf_pkg::ACT_READ, 1'b0, vkf_pkg::KEY_OTHER, vkf_pkg::CH_NUL, 7'd64,
          1'b0, NO_BEAT}
    };

    key_event_to_vt100_byte_fifo_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .key_pressed (key_pressed),
        .key_class   (key_class),
        .ascii_code  (ascii_code),
        .read_limit  (read_limit),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .has_byte    (has_byte),
        .last        (last),
        .fill_level  (fill_level)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Hard stop in case the block hangs or loses a beat
    initial
    begin
        #200_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Idle length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return 0;
        else if (r < 9)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // Read limit: mostly in range, now and then zero or above the maximum
    function automatic logic [vkf_pkg::LIMIT_W-1:0] pick_limit();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        else if (r < 3)
            return vkf_pkg::LIMIT_W'($urandom_range(vkf_pkg::MAX_READ + 1, 127));
        else
            return vkf_pkg::LIMIT_W'($urandom_range(1, vkf_pkg::MAX_READ));
    endfunction

    function automatic key_request_t key_event(input logic                        pressed,
                                               input logic [vkf_pkg::CLASS_W-1:0] cls,
                                               input logic [vkf_pkg::BYTE_W-1:0]  code);
        key_request_t r;
        r         = '0;
        r.act     = vkf_pkg::ACT_KEY;
        r.pressed = pressed;
        r.cls     = cls;
        r.code    = code;
        r.limit   = vkf_pkg::LIMIT_W'($urandom_range(0, 127));
        return r;
    endfunction

    // Key fields of a read carry noise: the block must ignore them
    function automatic key_request_t read_request(input logic [vkf_pkg::LIMIT_W-1:0] limit);
        key_request_t r;
        r         = '0;
        r.act     = vkf_pkg::ACT_READ;
        r.pressed = 1'($urandom_range(0, 1));
        r.cls     = vkf_pkg::CLASS_W'($urandom_range(0, 15));
        r.code    = vkf_pkg::BYTE_W'($urandom_range(0, 255));
        r.limit   = limit;
        return r;
    endfunction

    // Keystroke of a typed line: printable text, cursor keys, edits, releases
    function automatic key_request_t typed_key();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return key_event(1'b1, vkf_pkg::KEY_OTHER,
                             vkf_pkg::BYTE_W'($urandom_range(8'h20, 8'h7E)));
        else if (r < 8)
            return key_event(1'b1,
                             vkf_pkg::CLASS_W'($urandom_range(vkf_pkg::KEY_UP,
                                                              vkf_pkg::KEY_PGDN)),
                             vkf_pkg::BYTE_W'($urandom_range(0, 255)));
        else if (r == 8)
            return key_event(1'b1,
                             $urandom_range(0, 1) ? vkf_pkg::KEY_RET : vkf_pkg::KEY_BKSP,
                             $urandom_range(0, 1) ? vkf_pkg::CH_NUL
                                                  : vkf_pkg::BYTE_W'($urandom_range(1, 255)));
        else
            return key_event(1'b0, vkf_pkg::CLASS_W'($urandom_range(0, 15)),
                             vkf_pkg::BYTE_W'($urandom_range(0, 255)));
    endfunction

    // Push one byte; drop it when the ring is full
    function automatic void ring_store(input logic [vkf_pkg::BYTE_W-1:0] b);
        if (ring_count < vkf_pkg::RING_DEPTH)
        begin
            ring_copy[ring_wr] = b;
            ring_wr            = (ring_wr + 1) % vkf_pkg::RING_DEPTH;
            ring_count++;
        end
    endfunction

    // Advance the ring copy for one accepted request and queue the beats it causes.
    // Returns 0 for a key event that the block simply ignores.
    function automatic bit predict_request(input key_request_t req);
        logic [vkf_pkg::BYTE_W-1:0] c;
        logic [vkf_pkg::BYTE_W-1:0] final_char;
        int                         lim;
        int                         n;
        bit                         done;
        if (req.act == vkf_pkg::ACT_KEY)
        begin
            if (!req.pressed)
                return 1'b0;
            if (req.cls >= vkf_pkg::KEY_UP && req.cls <= vkf_pkg::KEY_PGDN)
            begin
                case (req.cls)
                    vkf_pkg::KEY_UP:    final_char = 8'h41;
                    vkf_pkg::KEY_DOWN:  final_char = 8'h42;
                    vkf_pkg::KEY_RIGHT: final_char = 8'h43;
                    vkf_pkg::KEY_LEFT:  final_char = 8'h44;
                    vkf_pkg::KEY_BOL:   final_char = 8'h48;
                    vkf_pkg::KEY_END:   final_char = 8'h46;
                    vkf_pkg::KEY_INS:   final_char = 8'h32;
                    vkf_pkg::KEY_DEL:   final_char = 8'h33;
                    vkf_pkg::KEY_PGUP:  final_char = 8'h35;
                    default:            final_char = 8'h36;
                endcase
                // each byte is dropped on its own, so a sequence may be cut short
                ring_store(vkf_pkg::CH_ESC);
                ring_store(vkf_pkg::CH_LBR);
                ring_store(final_char);
                if (req.cls >= vkf_pkg::KEY_INS)
                    ring_store(vkf_pkg::CH_TIL);
                return 1'b1;
            end
            c = req.code;
            if (req.cls == vkf_pkg::KEY_RET && c == vkf_pkg::CH_NUL)
                c = vkf_pkg::CH_LF;
            if (req.cls == vkf_pkg::KEY_BKSP && c == vkf_pkg::CH_NUL)
                c = vkf_pkg::CH_BS;
            if (c == vkf_pkg::CH_NUL)
                return 1'b0;
            ring_store(c);
            return 1'b1;
        end
        lim = (req.limit > vkf_pkg::MAX_READ) ? vkf_pkg::MAX_READ : int'(req.limit);
        if (ring_count == 0 || lim == 0)
        begin
            pending_beats.push_back('{vkf_pkg::CH_NUL, 1'b0, 1'b1,
                                      ring_count[vkf_pkg::FILL_W-1:0]});
            return 1'b1;
        end
        n = 0;
        do
        begin
            c       = ring_copy[ring_rd];
            ring_rd = (ring_rd + 1) % vkf_pkg::RING_DEPTH;
            ring_count--;
            done    = (n + 1 >= lim) || (c == vkf_pkg::CH_LF) || (ring_count == 0);
            pending_beats.push_back('{c, 1'b1, done, ring_count[vkf_pkg::FILL_W-1:0]});
            n++;
        end
        while (!done);
        return 1'b1;
    endfunction

    // Offer one request after a random gap and hold it until accepted
    task automatic send_request(input key_request_t req);
        int gap;
        gap = calm_sender ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        action      <= req.act;
        key_pressed <= req.pressed;
        key_class   <= req.cls;
        ascii_code  <= req.code;
        read_limit  <= req.limit;
        do
            @(posedge clk);
        while (in_stall);
        if (predict_request(req))
            work_items++;
    endtask

    // Drop valid and wait for every outstanding beat
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_beats.size() != 0);
    endtask

    // Result side: random stalls, calm stretches, and one long hold-off on request
    initial
    begin : result_sink
        int stall_left;
        bit calm;
        stall_left = 0;
        calm       = 1'b0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                // hold long enough for the block to back up and stall its input
                hold_off_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end
            else
            begin
                if ($urandom_range(0, 299) == 0)
                    calm = !calm;
                if (stall_left > 0)
                begin
                    stall_left--;
                    out_stall <= 1'b1;
                end
                else
                begin
                    out_stall <= 1'b0;
                    if (!calm && $urandom_range(0, 3) == 0)
                        stall_left = pick_gap();
                end
            end
        end
    end

    // Compare every accepted beat with the oldest expectation, field by field
    always @(posedge clk)
    begin : beat_check
        read_beat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_beats.size() == 0)
            begin
                $error("unexpected beat: out_byte %02h has_byte %0b last %0b fill_level %0d",
                       out_byte, has_byte, last, fill_level);
                mismatch_count++;
            end
            else
            begin
                want = pending_beats.pop_front();
                if (out_byte !== want.data)
                begin
                    $error("out_byte: expected %02h, got %02h", want.data, out_byte);
                    mismatch_count++;
                end
                if (has_byte !== want.has_data)
                begin
                    $error("has_byte: expected %0b, got %0b", want.has_data, has_byte);
                    mismatch_count++;
                end
                if (last !== want.closing)
                begin
                    $error("last: expected %0b, got %0b", want.closing, last);
                    mismatch_count++;
                end
                if (fill_level !== want.fill)
                begin
                    $error("fill_level: expected %0d, got %0d", want.fill, fill_level);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin : stimulus
        key_request_t req;
        bit           flooded;
        bit           held;
        flooded      = 1'b0;
        held         = 1'b0;
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        action      <= vkf_pkg::ACT_KEY;
        key_pressed <= 1'b0;
        key_class   <= vkf_pkg::KEY_OTHER;
        ascii_code  <= vkf_pkg::CH_NUL;
        read_limit  <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Walk the script; where a beat is typed in, it replaces the predicted one
        foreach (script[i])
        begin
            send_request(script[i]);
            if (script[i].typed)
            begin
                void'(pending_beats.pop_back());
                pending_beats.push_back(script[i].typed_beat);
            end
        end

        work_items = 0;
        while (work_items < RANDOM_ITEMS)
        begin
            calm_sender = ($urandom_range(0, 7) == 0);
            if (!flooded && work_items > 120)
            begin
                // Flood the ring well past full so bytes and sequences get dropped,
                // then drain it with reads of assorted limits
                flooded = 1'b1;
                wait_drained();
                repeat (FLOOD_KEYS)
                begin
                    if ($urandom_range(0, 7) == 0)
                        req = key_event(1'b1, vkf_pkg::KEY_OTHER,
                                        vkf_pkg::BYTE_W'($urandom_range(1, 255)));
                    else
                        req = key_event(1'b1,
                                        vkf_pkg::CLASS_W'($urandom_range(vkf_pkg::KEY_UP,
                                                                         vkf_pkg::KEY_PGDN)),
                                        vkf_pkg::BYTE_W'($urandom_range(0, 255)));
                    send_request(req);
                end
                // zero limit on a full ring reports the top fill level
                send_request(read_request('0));
                while (ring_count > 0)
                    send_request(read_request(pick_limit()));
                wait_drained();
            end
            else if (!held && work_items > 300)
            begin
                // Hold the result side while keys and reads keep arriving
                held = 1'b1;
                wait_drained();
                hold_off_req = 1'b1;
                repeat (30) send_request(typed_key());
                repeat (8) send_request(read_request(pick_limit()));
            end
            else if ($urandom_range(0, 9) < 7)
            begin
                // A typed line, usually closed by enter, then a few reads
                repeat ($urandom_range(1, 12)) send_request(typed_key());
                if ($urandom_range(0, 4) != 0)
                    send_request(key_event(1'b1, vkf_pkg::KEY_RET, vkf_pkg::CH_NUL));
                repeat ($urandom_range(1, 3)) send_request(read_request(pick_limit()));
            end
            else
            begin
                // Noise: every field at random
                repeat ($urandom_range(1, 6))
                begin
                    req         = '0;
                    req.act     = 1'($urandom_range(0, 1));
                    req.pressed = 1'($urandom_range(0, 1));
                    req.cls     = vkf_pkg::CLASS_W'($urandom_range(0, 15));
                    req.code    = vkf_pkg::BYTE_W'($urandom_range(0, 255));
                    req.limit   = vkf_pkg::LIMIT_W'($urandom_range(0, 127));
                    send_request(req);
                end
            end
            if ($urandom_range(0, 9) == 0)
                wait_drained();
        end

        // Let the last beats come out, then give a trailing key event time to settle
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
